// ===== design/tbfs_pkg.sv =====
// ----------------------------------------------------------------------------
// tbfs_pkg: shared types and constants of the tabu best-flip scan unit
// Field widths, register indexes, scan sentinels and the pipeline item types.
// ----------------------------------------------------------------------------
`default_nettype none

package tbfs_pkg;

  // Scan length and derived index width
  localparam int MaxItems = 65536;
  localparam int IDX_W    = $clog2(MaxItems);

  // Field widths
  localparam int VAL_W      = 32;
  localparam int ITER_W     = 48;
  localparam int SIZE_W     = 17;
  localparam int DELTA_W    = 33;
  localparam int INDEX_W    = 17;
  localparam int RECIP_W    = 33;
  localparam int DIV_W      = SIZE_W + 1;
  localparam int DIV_CNT_W  = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_VALUE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_BEST    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ITERATION     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_SIZE      = 3'd3;

  // Sentinels and fixed values
  localparam logic [DELTA_W-1:0]   DELTA_NONE  = {1'b1, {(DELTA_W-1){1'b0}}};
  localparam logic [INDEX_W-1:0]   INDEX_NONE  = {INDEX_W{1'b1}};
  localparam logic [RECIP_W-1:0]   RECIP_ONE   = {1'b1, {(RECIP_W-1){1'b0}}};
  localparam logic [SIZE_W-1:0]    MIN_REMOVE  = 17'd2;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS   = 6'(RECIP_W - 1);

  // Registered input item
  typedef struct packed {
    logic              valid;
    logic [VAL_W-1:0]  value;
    logic              member;
    logic [ITER_W-1:0] expiry;
    logic              last;
    logic [IDX_W-1:0]  index;
  } scan_item_t;

  // Item after the delta stage
  typedef struct packed {
    logic               valid;
    logic [DELTA_W-1:0] delta;
    logic               eligible;
    logic               tabu;
    logic               last;
    logic [IDX_W-1:0]   index;
  } delta_item_t;

  // Configuration register bundle
  typedef struct packed {
    logic [VAL_W-1:0]  current_value;
    logic [VAL_W-1:0]  local_best;
    logic [ITER_W-1:0] iteration;
    logic [SIZE_W-1:0] set_size;
  } scan_cfg_t;

  // Reciprocal pair
  typedef struct packed {
    logic [RECIP_W-1:0] add;
    logic [RECIP_W-1:0] remove;
  } recip_pair_t;

endpackage

`default_nettype wire

// ===== design/tabu_best_flip_scan_unit.sv =====
// The last element of a scan passes the input register, the gain stage register and the
// result register before out_valid rises. Throughput: one element per cycle while
// in_stall is low; multiply and running-best update overlap. A last element stalls
// while the previous result still waits on out_stall. A set_size write starts the
// reciprocal division (one quotient bit per cycle); in_stall and cfg_ready hold off
// new transactions until it completes. Reset (synchronous, rst_n low) zeroes the config
// and counter registers, presets the reciprocals and clears the running best and valids.
// tabu_best_flip_scan_unit: best-flip scan of a mean-dispersion tabu search
// Input register, gain stage, running best with result register, and the
// reciprocal generator behind the configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

module tabu_best_flip_scan_unit (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // configuration
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire [tbfs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [tbfs_pkg::CFG_DATA_W-1:0]      cfg_data,
  // input channel
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire signed [tbfs_pkg::VAL_W-1:0]    in_element_value,
  input  wire                                 in_in_set,
  input  wire [tbfs_pkg::ITER_W-1:0]          in_tabu_expiry,
  input  wire                                 in_last_item,
  // result channel
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic signed [tbfs_pkg::INDEX_W-1:0] out_best_index,
  output logic signed [tbfs_pkg::DELTA_W-1:0] out_best_delta,
  output logic                                out_found
);

  tbfs_pkg::scan_cfg_t          cfg_r, cfg_nxt;
  tbfs_pkg::scan_item_t         stage_r, stage_nxt;
  logic [tbfs_pkg::IDX_W-1:0]   count_r, count_nxt;
  tbfs_pkg::recip_pair_t        recip;
  tbfs_pkg::delta_item_t        delta_item;
  logic                         div_busy, div_start, cfg_write, in_accept, hold;
  logic [tbfs_pkg::INDEX_W-1:0] track_index;
  logic [tbfs_pkg::DELTA_W-1:0] track_delta;

  assign cfg_ready = !div_busy;
  assign cfg_write = cfg_valid && cfg_ready;
  assign div_start = cfg_write && (cfg_index == tbfs_pkg::CFG_SET_SIZE);
  assign in_stall  = hold || div_busy;
  assign in_accept = in_valid && !in_stall;

  // Register file write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_write) begin
      case (cfg_index)
        tbfs_pkg::CFG_CURRENT_VALUE: cfg_nxt.current_value = cfg_data[tbfs_pkg::VAL_W-1:0];
        tbfs_pkg::CFG_LOCAL_BEST:    cfg_nxt.local_best    = cfg_data[tbfs_pkg::VAL_W-1:0];
        tbfs_pkg::CFG_ITERATION:     cfg_nxt.iteration     = cfg_data[tbfs_pkg::ITER_W-1:0];
        tbfs_pkg::CFG_SET_SIZE:      cfg_nxt.set_size      = cfg_data[tbfs_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register and element numbering
  always_comb begin
    stage_nxt = stage_r;
    count_nxt = count_r;
    if (!hold) begin
      stage_nxt.valid  = in_accept;
      stage_nxt.value  = in_element_value;
      stage_nxt.member = in_in_set;
      stage_nxt.expiry = in_tabu_expiry;
      stage_nxt.last   = in_last_item;
      stage_nxt.index  = count_r;
    end
    if (in_accept) begin
      count_nxt = in_last_item ? '0 : count_r + tbfs_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r         <= '0;
      count_r       <= '0;
      stage_r.valid <= 1'b0;
    end else begin
      cfg_r         <= cfg_nxt;
      count_r       <= count_nxt;
      stage_r.valid <= stage_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    stage_r.value  <= stage_nxt.value;
    stage_r.member <= stage_nxt.member;
    stage_r.expiry <= stage_nxt.expiry;
    stage_r.last   <= stage_nxt.last;
    stage_r.index  <= stage_nxt.index;
  end

  tbfs_recip_div u_recip_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .size  (cfg_data[tbfs_pkg::SIZE_W-1:0]),
    .busy  (div_busy),
    .recip (recip)
  );

  tbfs_delta_stage u_delta_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (!hold),
    .item    (stage_r),
    .cfg     (cfg_r),
    .recip   (recip),
    .result  (delta_item)
  );

  tbfs_best_track u_best_track (
    .clk            (clk),
    .rst_n          (rst_n),
    .item           (delta_item),
    .cfg            (cfg_r),
    .hold           (hold),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_best_index (track_index),
    .out_best_delta (track_delta),
    .out_found      (out_found)
  );

  assign out_best_index = $signed(track_index);
  assign out_best_delta = $signed(track_delta);

endmodule

`default_nettype wire

// ===== design/tbfs_recip_div.sv =====
// ----------------------------------------------------------------------------
// tbfs_recip_div: reciprocal generator
// Restoring division of 2^32 by (size+1) and (size-1), one quotient bit per
// cycle in two lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module tbfs_recip_div (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  wire [tbfs_pkg::SIZE_W-1:0]   size,
  output logic                         busy,
  output tbfs_pkg::recip_pair_t        recip
);

  logic                             busy_r, busy_nxt;
  logic [tbfs_pkg::DIV_CNT_W-1:0]   count_r, count_nxt;
  logic [tbfs_pkg::DIV_W-1:0]       div_a_r, div_a_nxt, div_b_r, div_b_nxt;
  logic [tbfs_pkg::SIZE_W-1:0]      part_a_r, part_a_nxt, part_b_r, part_b_nxt;
  logic [tbfs_pkg::RECIP_W-1:0]     quo_a_r, quo_a_nxt, quo_b_r, quo_b_nxt;
  logic                             keep_b_r, keep_b_nxt;
  tbfs_pkg::recip_pair_t            recip_r, recip_nxt;
  logic                             shift_bit;
  logic [tbfs_pkg::DIV_W-1:0]       trial_a, trial_b;
  logic                             fit_a, fit_b;

  // Dividend is 2^32: only its top bit is set
  assign shift_bit = (count_r == tbfs_pkg::DIV_STEPS);
  assign trial_a   = {part_a_r, shift_bit};
  assign trial_b   = {part_b_r, shift_bit};
  assign fit_a     = (trial_a >= div_a_r);
  assign fit_b     = (trial_b >= div_b_r);

  // Advance one quotient bit per cycle while busy, load results on the final step
  always_comb begin
    busy_nxt   = busy_r;
    count_nxt  = count_r;
    div_a_nxt  = div_a_r;
    div_b_nxt  = div_b_r;
    part_a_nxt = part_a_r;
    part_b_nxt = part_b_r;
    quo_a_nxt  = quo_a_r;
    quo_b_nxt  = quo_b_r;
    keep_b_nxt = keep_b_r;
    recip_nxt  = recip_r;
    if (start) begin
      busy_nxt   = 1'b1;
      count_nxt  = tbfs_pkg::DIV_STEPS;
      div_a_nxt  = {1'b0, size} + tbfs_pkg::DIV_W'(1);
      div_b_nxt  = {1'b0, size} - tbfs_pkg::DIV_W'(1);
      part_a_nxt = '0;
      part_b_nxt = '0;
      quo_a_nxt  = '0;
      quo_b_nxt  = '0;
      keep_b_nxt = (size > tbfs_pkg::MIN_REMOVE);
    end else if (busy_r) begin
      part_a_nxt = fit_a ? tbfs_pkg::SIZE_W'(trial_a - div_a_r)
                         : tbfs_pkg::SIZE_W'(trial_a);
      part_b_nxt = fit_b ? tbfs_pkg::SIZE_W'(trial_b - div_b_r)
                         : tbfs_pkg::SIZE_W'(trial_b);
      quo_a_nxt  = {quo_a_r[tbfs_pkg::RECIP_W-2:0], fit_a};
      quo_b_nxt  = {quo_b_r[tbfs_pkg::RECIP_W-2:0], fit_b};
      if (count_r == '0) begin
        busy_nxt         = 1'b0;
        recip_nxt.add    = quo_a_nxt;
        recip_nxt.remove = keep_b_r ? quo_b_nxt : '0;
      end else begin
        count_nxt = count_r - tbfs_pkg::DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r           <= 1'b0;
      count_r          <= '0;
      recip_r.add      <= tbfs_pkg::RECIP_ONE;
      recip_r.remove   <= '0;
    end else begin
      busy_r  <= busy_nxt;
      count_r <= count_nxt;
      recip_r <= recip_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_a_r  <= div_a_nxt;
    div_b_r  <= div_b_nxt;
    part_a_r <= part_a_nxt;
    part_b_r <= part_b_nxt;
    quo_a_r  <= quo_a_nxt;
    quo_b_r  <= quo_b_nxt;
    keep_b_r <= keep_b_nxt;
  end

  assign busy  = busy_r;
  assign recip = recip_r;

  // A refresh always starts the sequencer
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r)
    else $error("reciprocal refresh did not start");

  // The final step ends the refresh
  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !start && count_r == '0 |=> !busy_r)
    else $error("reciprocal refresh did not finish");

  // Idle sequencer holds the results
  a_idle_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r && !start |=> $stable(recip_r))
    else $error("reciprocals changed while idle");

endmodule

`default_nettype wire

// ===== design/tbfs_delta_stage.sv =====
// ----------------------------------------------------------------------------
// tbfs_delta_stage: gain computation
// Forms the difference, scales it by the reciprocal with floor rounding and
// checks the tabu state; result registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tbfs_delta_stage (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     advance,
  input  tbfs_pkg::scan_item_t    item,
  input  tbfs_pkg::scan_cfg_t     cfg,
  input  tbfs_pkg::recip_pair_t   recip,
  output tbfs_pkg::delta_item_t   result
);

  tbfs_pkg::delta_item_t               result_r, result_nxt;
  logic signed [tbfs_pkg::DELTA_W-1:0] val_ext, cur_ext, diff;
  logic [tbfs_pkg::RECIP_W-1:0]        recip_sel;
  logic signed [2*tbfs_pkg::DELTA_W-1:0] prod;
  logic [tbfs_pkg::DELTA_W-1:0]        delta;

  // Signed difference, direction set by membership
  assign val_ext = $signed({item.value[tbfs_pkg::VAL_W-1], item.value});
  assign cur_ext = $signed({cfg.current_value[tbfs_pkg::VAL_W-1], cfg.current_value});
  assign diff      = item.member ? (cur_ext - val_ext) : (val_ext - cur_ext);
  assign recip_sel = item.member ? recip.remove : recip.add;

  // Scale by reciprocal; arithmetic shift floors toward minus infinity
  assign prod  = diff * $signed({1'b0, recip_sel[tbfs_pkg::RECIP_W-2:0]});
  assign delta = recip_sel[tbfs_pkg::RECIP_W-1] ? diff
               : prod[tbfs_pkg::DELTA_W+tbfs_pkg::VAL_W-1:tbfs_pkg::VAL_W];

  always_comb begin
    result_nxt = result_r;
    if (advance) begin
      result_nxt.valid    = item.valid;
      result_nxt.delta    = delta;
      result_nxt.eligible = !item.member || (cfg.set_size > tbfs_pkg::MIN_REMOVE);
      result_nxt.tabu     = (item.expiry > cfg.iteration);
      result_nxt.last     = item.last;
      result_nxt.index    = item.index;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      result_r.valid <= 1'b0;
    end else begin
      result_r.valid <= result_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    result_r.delta    <= result_nxt.delta;
    result_r.eligible <= result_nxt.eligible;
    result_r.tabu     <= result_nxt.tabu;
    result_r.last     <= result_nxt.last;
    result_r.index    <= result_nxt.index;
  end

  assign result = result_r;

endmodule

`default_nettype wire

// ===== design/tbfs_best_track.sv =====
// ----------------------------------------------------------------------------
// tbfs_best_track: running best and result register
// Applies aspiration, keeps the best admissible move and emits it on the
// last element of a scan.
// ----------------------------------------------------------------------------
`default_nettype none

module tbfs_best_track (
  input  wire                              clk,
  input  wire                              rst_n,
  input  tbfs_pkg::delta_item_t            item,
  input  tbfs_pkg::scan_cfg_t              cfg,
  output logic                             hold,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [tbfs_pkg::INDEX_W-1:0]     out_best_index,
  output logic [tbfs_pkg::DELTA_W-1:0]     out_best_delta,
  output logic                             out_found
);

  logic [tbfs_pkg::DELTA_W-1:0] best_delta_r, best_delta_nxt;
  logic [tbfs_pkg::INDEX_W-1:0] best_index_r, best_index_nxt;
  logic                         any_found_r, any_found_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [tbfs_pkg::INDEX_W-1:0] out_index_r, out_index_nxt;
  logic [tbfs_pkg::DELTA_W-1:0] out_delta_r, out_delta_nxt;
  logic                         out_found_r, out_found_nxt;
  logic signed [tbfs_pkg::DELTA_W:0] asp_sum, asp_ref;
  logic                         aspire, admit, better, update, retire;
  logic [tbfs_pkg::DELTA_W-1:0] cand_delta;
  logic [tbfs_pkg::INDEX_W-1:0] cand_index;
  logic                         cand_found;

  // Hold the closing transaction while the result register is occupied and out_stall is high
  assign hold   = item.valid && item.last && out_valid_r && out_stall;
  assign retire = item.valid && !hold;

  // Aspiration: current plus delta must beat the local best
  assign asp_sum = $signed({{2{cfg.current_value[tbfs_pkg::VAL_W-1]}}, cfg.current_value})
                 + $signed({item.delta[tbfs_pkg::DELTA_W-1], item.delta});
  assign asp_ref = $signed({{2{cfg.local_best[tbfs_pkg::VAL_W-1]}}, cfg.local_best});
  assign aspire  = (asp_sum > asp_ref);
  assign admit   = item.eligible && (!item.tabu || aspire);

  // Strictly greater wins, so the earliest index keeps ties
  assign better = !any_found_r || ($signed(item.delta) > $signed(best_delta_r));
  assign update = admit && better;

  assign cand_delta = update ? item.delta : best_delta_r;
  assign cand_index = update ? {1'b0, item.index} : best_index_r;
  assign cand_found = update || any_found_r;

  // Advance running best, close scan on the last element
  always_comb begin
    best_delta_nxt = best_delta_r;
    best_index_nxt = best_index_r;
    any_found_nxt  = any_found_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_index_nxt  = out_index_r;
    out_delta_nxt  = out_delta_r;
    out_found_nxt  = out_found_r;
    if (retire) begin
      if (item.last) begin
        out_valid_nxt  = 1'b1;
        out_index_nxt  = cand_index;
        out_delta_nxt  = cand_delta;
        out_found_nxt  = cand_found;
        best_delta_nxt = tbfs_pkg::DELTA_NONE;
        best_index_nxt = tbfs_pkg::INDEX_NONE;
        any_found_nxt  = 1'b0;
      end else begin
        best_delta_nxt = cand_delta;
        best_index_nxt = cand_index;
        any_found_nxt  = cand_found;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_delta_r <= tbfs_pkg::DELTA_NONE;
      best_index_r <= tbfs_pkg::INDEX_NONE;
      any_found_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      best_delta_r <= best_delta_nxt;
      best_index_r <= best_index_nxt;
      any_found_r  <= any_found_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_index_r <= out_index_nxt;
    out_delta_r <= out_delta_nxt;
    out_found_r <= out_found_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_best_index = out_index_r;
  assign out_best_delta = out_delta_r;
  assign out_found      = out_found_r;

  // Closing a scan clears the running best
  a_scan_clear: assert property (@(posedge clk) disable iff (!rst_n)
    retire && item.last |=> !any_found_r && best_index_r == tbfs_pkg::INDEX_NONE)
    else $error("running best not cleared at scan close");

  // An empty result carries the sentinels
  a_none_sentinel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |->
      out_index_r == tbfs_pkg::INDEX_NONE && out_delta_r == tbfs_pkg::DELTA_NONE)
    else $error("empty result without sentinels");

  // A found move always has a real index
  a_found_index: assert property (@(posedge clk) disable iff (!rst_n)
    any_found_r |-> best_index_r != tbfs_pkg::INDEX_NONE)
    else $error("found move without index");

endmodule

`default_nettype wire
